FILE: sv/assert_macros.svh
// Assertion shorthands used by the jasm_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define JASM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define JASM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/jasm_pkg.sv
package jasm_pkg;

    // Normalised travel is a Q1.16 value from 0 up to exactly 1.0.
    localparam int NORM_FRAC = 16;
    localparam int NORM_W    = NORM_FRAC + 1;
    localparam int DIV_CNT_W = $clog2(NORM_FRAC);

    localparam logic [NORM_W-1:0] NORM_ONE = {1'b1, {NORM_FRAC{1'b0}}};

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_STOP   = 2'd0;
    localparam t_cmd CMD_FWD    = 2'd1;
    localparam t_cmd CMD_BACK   = 2'd2;
    localparam t_cmd CMD_UPDATE = 2'd3;

    typedef logic [1:0] t_dir;
    localparam t_dir DIR_STOP = 2'd0;
    localparam t_dir DIR_FWD  = 2'd1;
    localparam t_dir DIR_BACK = 2'd2;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEADZONE   = 3'd0;
    localparam t_cfg_idx CFG_MAX_SPEED  = 3'd1;
    localparam t_cfg_idx CFG_MIN_SPEED  = 3'd2;
    localparam t_cfg_idx CFG_HYSTERESIS = 3'd3;
    localparam t_cfg_idx CFG_EXPONENT   = 3'd4;

    typedef logic [1:0] t_exp;

    localparam int   RST_DEADZONE   = 8192;
    localparam int   RST_MAX_SPEED  = 16000;
    localparam int   RST_MIN_SPEED  = 250;
    localparam int   RST_HYSTERESIS = 300;
    localparam t_exp RST_EXPONENT   = 2'd2;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic norm_load;
        logic mul_pow;
        logic mul_scale;
        logic clamp;
        logic decide;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_dz;
        logic div_done;
        logic pow_more;
        logic out_full;
    } t_dp_status;

endpackage

FILE: sv/jasm_cfg.sv
module jasm_cfg #(
    parameter int AXIS_BITS  = 16,
    parameter int SPEED_BITS = 16,
    localparam int DZ_W  = AXIS_BITS - 1,
    localparam int CFG_W = (SPEED_BITS > DZ_W) ? SPEED_BITS : DZ_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  jasm_pkg::t_cfg_idx   i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic [DZ_W-1:0]      o_deadzone,
    output logic [SPEED_BITS-1:0] o_max_speed,
    output logic [SPEED_BITS-1:0] o_min_speed,
    output logic [SPEED_BITS-1:0] o_hysteresis,
    output jasm_pkg::t_exp       o_exponent
);
    import jasm_pkg::*;

    logic [DZ_W-1:0]       r_deadzone;
    logic [SPEED_BITS-1:0] r_max_speed;
    logic [SPEED_BITS-1:0] r_min_speed;
    logic [SPEED_BITS-1:0] r_hysteresis;
    t_exp                  r_exponent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= DZ_W'(RST_DEADZONE);
            r_max_speed  <= SPEED_BITS'(RST_MAX_SPEED);
            r_min_speed  <= SPEED_BITS'(RST_MIN_SPEED);
            r_hysteresis <= SPEED_BITS'(RST_HYSTERESIS);
            r_exponent   <= RST_EXPONENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEADZONE:   r_deadzone   <= i_cfg_wdata[DZ_W-1:0];
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_wdata[SPEED_BITS-1:0];
                CFG_MIN_SPEED:  r_min_speed  <= i_cfg_wdata[SPEED_BITS-1:0];
                CFG_HYSTERESIS: r_hysteresis <= i_cfg_wdata[SPEED_BITS-1:0];
                CFG_EXPONENT:   r_exponent   <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_deadzone   = r_deadzone;
    assign o_max_speed  = r_max_speed;
    assign o_min_speed  = r_min_speed;
    assign o_hysteresis = r_hysteresis;
    assign o_exponent   = r_exponent;

endmodule

FILE: sv/jasm_ctrl.sv
module jasm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  jasm_pkg::t_dp_status i_status,
    output jasm_pkg::t_ctrl_cmd  o_cmd
);
    import jasm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_NORM   = 3'd3;
    localparam logic [2:0] S_POW    = 3'd4;
    localparam logic [2:0] S_CLAMP  = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.in_dz) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm_load = 1'b1;
                n_state         = S_POW;
            end
            S_POW: begin
                // Further powers first, then the final scaling by the top speed.
                if (i_status.pow_more) begin
                    o_cmd.mul_pow = 1'b1;
                end else begin
                    o_cmd.mul_scale = 1'b1;
                    n_state         = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_status.out_full) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: sv/jasm_dp.sv
module jasm_dp #(
    parameter int AXIS_BITS  = 16,
    parameter int SPEED_BITS = 16,
    localparam int DZ_W = AXIS_BITS - 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jasm_pkg::t_ctrl_cmd   i_cmd,
    output jasm_pkg::t_dp_status  o_status,
    input  logic [AXIS_BITS-1:0]  i_axis_value,
    input  logic [DZ_W-1:0]       i_deadzone,
    input  logic [SPEED_BITS-1:0] i_max_speed,
    input  logic [SPEED_BITS-1:0] i_min_speed,
    input  logic [SPEED_BITS-1:0] i_hysteresis,
    input  jasm_pkg::t_exp        i_exponent,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output jasm_pkg::t_cmd        o_command,
    output logic [SPEED_BITS-1:0] o_speed_hz
);
    import jasm_pkg::*;

    localparam int MUL_B_W = (SPEED_BITS > NORM_W) ? SPEED_BITS : NORM_W;
    localparam int PROD_W  = NORM_W + MUL_B_W;
    localparam logic [AXIS_BITS-1:0] AXIS_FULL = {1'b1, {(AXIS_BITS-1){1'b0}}};

    logic [AXIS_BITS-1:0]  r_axis;
    logic [AXIS_BITS-1:0]  r_rem;
    logic [NORM_FRAC-1:0]  r_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic                  r_sat;
    logic [NORM_W-1:0]     r_norm;
    logic [NORM_W-1:0]     r_p;
    t_exp                  r_pow_cnt;
    logic [SPEED_BITS-1:0] r_target;
    t_dir                  r_last_dir;
    logic [SPEED_BITS-1:0] r_last_speed;
    logic                  r_out_valid;
    t_cmd                  r_command;
    logic [SPEED_BITS-1:0] r_speed;

    logic                  w_neg;
    logic [AXIS_BITS-1:0]  w_mag;
    logic [AXIS_BITS-1:0]  w_dz;
    logic                  w_inside;
    logic [AXIS_BITS-1:0]  w_diff;
    logic [AXIS_BITS-1:0]  w_div;
    logic [AXIS_BITS:0]    w_rem_sh;
    logic [AXIS_BITS:0]    w_rem_sub;
    logic                  w_ge;
    logic [NORM_W-1:0]     w_norm;
    t_exp                  w_pow_init;
    logic [MUL_B_W-1:0]    w_mul_b;
    logic [PROD_W-1:0]     w_prod;
    t_dir                  w_dir;
    logic [SPEED_BITS-1:0] w_sdiff;
    logic                  w_upd;

    logic                  n_emit;
    t_cmd                  n_command;
    logic [SPEED_BITS-1:0] n_speed;
    t_dir                  n_last_dir;
    logic [SPEED_BITS-1:0] n_last_speed;

    assign w_neg    = r_axis[AXIS_BITS-1];
    assign w_mag    = w_neg ? AXIS_BITS'(~r_axis + 1'b1) : r_axis;
    assign w_dz     = {1'b0, i_deadzone};
    assign w_inside = (w_mag <= w_dz);
    assign w_diff   = w_mag - w_dz;
    assign w_div    = AXIS_FULL - w_dz;

    // Restoring divider, one quotient bit per cycle.
    assign w_rem_sh  = {r_rem, 1'b0};
    assign w_rem_sub = w_rem_sh - {1'b0, w_div};
    assign w_ge      = (w_rem_sh >= {1'b0, w_div});

    assign w_norm     = r_sat ? NORM_ONE : {1'b0, r_quo};
    assign w_pow_init = (i_exponent == 2'd0) ? 2'd0 : i_exponent - 2'd1;

    // One shared multiplier: powers of the fraction, then scaling by the top speed.
    assign w_mul_b = i_cmd.mul_pow ? MUL_B_W'(r_norm) : MUL_B_W'(i_max_speed);
    assign w_prod  = PROD_W'(r_p) * PROD_W'(w_mul_b);

    assign w_dir   = w_neg ? DIR_BACK : DIR_FWD;
    assign w_sdiff = (r_target > r_last_speed) ? (r_target - r_last_speed)
                                               : (r_last_speed - r_target);
    assign w_upd   = (w_sdiff > i_hysteresis);

    always_comb begin
        n_emit       = 1'b0;
        n_command    = CMD_STOP;
        n_speed      = '0;
        n_last_dir   = r_last_dir;
        n_last_speed = r_last_speed;
        if (w_inside) begin
            if (r_last_dir != DIR_STOP) begin
                n_emit       = 1'b1;
                n_last_dir   = DIR_STOP;
                n_last_speed = '0;
            end
        end else if (w_dir != r_last_dir) begin
            n_emit       = 1'b1;
            n_command    = w_neg ? CMD_BACK : CMD_FWD;
            n_speed      = r_target;
            n_last_dir   = w_dir;
            n_last_speed = r_target;
        end else if (w_upd) begin
            n_emit       = 1'b1;
            n_command    = CMD_UPDATE;
            n_speed      = r_target;
            n_last_speed = r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis <= i_axis_value;
        end
        if (i_cmd.div_init) begin
            r_rem     <= w_diff;
            r_quo     <= '0;
            r_div_cnt <= '0;
            r_sat     <= (w_diff >= w_div);
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_ge ? w_rem_sub[AXIS_BITS-1:0] : w_rem_sh[AXIS_BITS-1:0];
            r_quo     <= {r_quo[NORM_FRAC-2:0], w_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.norm_load) begin
            r_norm    <= w_norm;
            r_p       <= w_norm;
            r_pow_cnt <= w_pow_init;
        end
        if (i_cmd.mul_pow) begin
            r_p       <= w_prod[NORM_FRAC +: NORM_W];
            r_pow_cnt <= r_pow_cnt - 2'd1;
        end
        if (i_cmd.mul_scale) begin
            r_target <= w_prod[NORM_FRAC +: SPEED_BITS];
        end
        if (i_cmd.clamp && (r_target < i_min_speed)) begin
            r_target <= i_min_speed;
        end
        if (i_cmd.decide && n_emit) begin
            r_command <= n_command;
            r_speed   <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dir   <= DIR_STOP;
            r_last_speed <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_last_dir   <= n_last_dir;
                r_last_speed <= n_last_speed;
                if (n_emit) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    assign o_status.in_dz    = w_inside;
    assign o_status.div_done = (r_div_cnt == DIV_CNT_W'(NORM_FRAC - 1));
    assign o_status.pow_more = (r_pow_cnt != 2'd0);
    assign o_status.out_full = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_command   = r_command;
    assign o_speed_hz  = r_speed;

endmodule

FILE: sv/joystick_axis_speed_mapper.sv
// Joystick axis to stepper speed mapper.
// Input channel: i_in_valid / o_in_stall carry one signed axis sample per request
// (i_axis_value). Output channel: o_out_valid / i_out_stall carry zero or one
// command per sample (o_command, o_speed_hz). Registers are written through
// i_cfg_we / i_cfg_index / i_cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. A sample inside the
// deadzone goes from the check straight to the decision. Outside it the restoring
// divider yields the normalised travel bit by bit, the shared multiplier raises it
// to the curve exponent and scales it by the top speed, and the result is clamped
// to the minimum speed. One sample is processed at a time.
// The result sits in an output register, so a stalled receiver only holds the
// block once the next result is ready to be written.
// Synchronous reset restores the register defaults, marks the axis as stopped at
// zero speed and drops any pending output request.
module joystick_axis_speed_mapper #(
    parameter int SPEED_BITS = 16,
    parameter int AXIS_BITS  = 16,
    localparam int DZ_W  = AXIS_BITS - 1,
    localparam int CFG_W = (SPEED_BITS > DZ_W) ? SPEED_BITS : DZ_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [AXIS_BITS-1:0] i_axis_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output jasm_pkg::t_cmd        o_command,
    output logic [SPEED_BITS-1:0] o_speed_hz,
    input  logic                  i_cfg_we,
    input  jasm_pkg::t_cfg_idx    i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);
    import jasm_pkg::*;

    t_ctrl_cmd             w_cmd;
    t_dp_status            w_status;
    logic [DZ_W-1:0]       w_deadzone;
    logic [SPEED_BITS-1:0] w_max_speed;
    logic [SPEED_BITS-1:0] w_min_speed;
    logic [SPEED_BITS-1:0] w_hysteresis;
    t_exp                  w_exponent;

    jasm_cfg #(
        .AXIS_BITS  (AXIS_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_deadzone   (w_deadzone),
        .o_max_speed  (w_max_speed),
        .o_min_speed  (w_min_speed),
        .o_hysteresis (w_hysteresis),
        .o_exponent   (w_exponent)
    );

    jasm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jasm_dp #(
        .AXIS_BITS  (AXIS_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_axis_value (i_axis_value),
        .i_deadzone   (w_deadzone),
        .i_max_speed  (w_max_speed),
        .i_min_speed  (w_min_speed),
        .i_hysteresis (w_hysteresis),
        .i_exponent   (w_exponent),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_command    (o_command),
        .o_speed_hz   (o_speed_hz)
    );

endmodule

FILE: sv/jasm_chk.sv
`include "assert_macros.svh"

module jasm_chk #(
    parameter int SPEED_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input jasm_pkg::t_cmd        o_command,
    input logic [SPEED_BITS-1:0] o_speed_hz
);
    import jasm_pkg::*;

    // A stalled result request keeps its payload.
    `JASM_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_command) && $stable(o_speed_hz)), "stalled result changed")

    // Samples are worked on one at a time, so taking one closes the input.
    `JASM_ASSERT(a_one_at_a_time, (i_in_valid && !o_in_stall) |=> o_in_stall, "second sample taken while busy")

    // A stop command always carries zero speed.
    `JASM_ASSERT(a_stop_zero, (o_out_valid && (o_command == CMD_STOP)) |-> (o_speed_hz == '0), "stop with non-zero speed")

    // Reset drops any pending result.
    `JASM_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "result pending after reset")

endmodule

bind joystick_axis_speed_mapper jasm_chk #(
    .SPEED_BITS (SPEED_BITS)
) u_jasm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_command   (o_command),
    .o_speed_hz  (o_speed_hz)
);

FILE: dv/jasm_checker.sv
module jasm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_axis_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  jasm_pkg::t_cmd     i_command,
    input  logic [15:0]        i_speed_hz,
    input  logic               i_cfg_we,
    input  jasm_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_errors,
    output int                 o_pending
);
    import jasm_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] speed;
    } t_speed_cmd;

    // Shadow copies of the registers and of the block's motion state.
    logic [14:0] dz_q;
    logic [15:0] max_q;
    logic [15:0] min_q;
    logic [15:0] hyst_q;
    t_exp        exp_q;
    t_dir        last_dir;
    logic [15:0] last_spd;

    t_speed_cmd  awaited_cmds[$];

    // Speed for a magnitude that lies outside the deadzone.
    function automatic logic [15:0] curve_target(input logic [16:0] mag);
        logic [63:0] norm;
        logic [63:0] curved;
        logic [63:0] scaled;
        logic [15:0] target;
        int          n_pow;
        norm = ((64'(mag) - 64'(dz_q)) << 16) / (64'd32768 - 64'(dz_q));
        if (norm > 64'd65536) begin
            norm = 64'd65536;
        end
        curved = norm;
        // An exponent of zero behaves as linear.
        n_pow = (exp_q == 2'd0) ? 1 : int'(exp_q);
        for (int k = 2; k <= n_pow; k++) begin
            curved = (curved * norm) >> 16;
        end
        scaled = (curved * 64'(max_q)) >> 16;
        target = scaled[15:0];
        if (target < min_q) begin
            target = min_q;
        end
        return target;
    endfunction

    always @(posedge i_clk) begin
        t_speed_cmd  want;
        logic [16:0] mag;
        logic [15:0] target;
        logic [15:0] diff;
        t_dir        dir;
        if (!i_rst_n) begin
            dz_q     = 15'(RST_DEADZONE);
            max_q    = 16'(RST_MAX_SPEED);
            min_q    = 16'(RST_MIN_SPEED);
            hyst_q   = 16'(RST_HYSTERESIS);
            exp_q    = RST_EXPONENT;
            last_dir = DIR_STOP;
            last_spd = '0;
            awaited_cmds.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_cmds.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected command %0d speed %0d", $time, i_command,
                             i_speed_hz);
                end else begin
                    want = awaited_cmds.pop_front();
                    if (i_command !== want.cmd) begin
                        o_errors++;
                        $display("%0t: command expected %0d, got %0d", $time, want.cmd,
                                 i_command);
                    end
                    if (i_speed_hz !== want.speed) begin
                        o_errors++;
                        $display("%0t: speed_hz expected %0d, got %0d", $time, want.speed,
                                 i_speed_hz);
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEADZONE:   dz_q   = i_cfg_wdata[14:0];
                    CFG_MAX_SPEED:  max_q  = i_cfg_wdata;
                    CFG_MIN_SPEED:  min_q  = i_cfg_wdata;
                    CFG_HYSTERESIS: hyst_q = i_cfg_wdata;
                    CFG_EXPONENT:   exp_q  = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                mag = i_axis_value[15] ? (17'h10000 - {1'b0, i_axis_value})
                                       : {1'b0, i_axis_value};
                if (mag <= {2'b00, dz_q}) begin
                    // Only a moving axis is told to stop.
                    if (last_dir != DIR_STOP) begin
                        last_dir   = DIR_STOP;
                        last_spd   = '0;
                        want.cmd   = CMD_STOP;
                        want.speed = '0;
                        awaited_cmds.push_back(want);
                    end
                end else begin
                    target = curve_target(mag);
                    dir    = i_axis_value[15] ? DIR_BACK : DIR_FWD;
                    if (dir != last_dir) begin
                        last_dir   = dir;
                        last_spd   = target;
                        want.cmd   = (dir == DIR_FWD) ? CMD_FWD : CMD_BACK;
                        want.speed = target;
                        awaited_cmds.push_back(want);
                    end else begin
                        diff = (target > last_spd) ? target - last_spd : last_spd - target;
                        if (diff > hyst_q) begin
                            last_spd   = target;
                            want.cmd   = CMD_UPDATE;
                            want.speed = target;
                            awaited_cmds.push_back(want);
                        end
                    end
                end
            end
        end
        o_pending = awaited_cmds.size();
    end

endmodule

FILE: dv/tb.sv
module tb;
    import jasm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 30;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 140;
    localparam t_cfg_idx CFG_FIRST_UNUSED = CFG_EXPONENT + 3'd1;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic signed [15:0] axis_value;
    logic              out_valid;
    logic              out_stall;
    t_cmd              command;
    logic [15:0]       speed_hz;
    logic              cfg_we;
    t_cfg_idx          cfg_index;
    logic [15:0]       cfg_wdata;

    int errors;
    int pending;
    int in_idle_pct;
    int out_stall_pct;
    int cur_dz;
    int quiet_cycles;

    joystick_axis_speed_mapper dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_axis_value (axis_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_command    (command),
        .o_speed_hz   (speed_hz),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata)
    );

    jasm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_axis_value (axis_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_command    (command),
        .i_speed_hz   (speed_hz),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Ends the run if neither channel moves a request for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // Called and returns at a falling edge; valid stays high so that back-to-back
    // requests need no extra assignment.
    task automatic send_sample(input int value);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        axis_value <= 16'(value);
        do begin
            @(posedge clk);
        end while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    // Waits until every command has come out and the block has finished any sample
    // that gives none.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_TIME) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    task automatic write_config(input int dz, input int max_spd, input int min_spd,
                                input int hyst, input int expo);
        // The deadzone register is one bit narrower; the spare bit is driven at random.
        write_reg(CFG_DEADZONE, {1'($urandom_range(1)), 15'(dz)});
        write_reg(CFG_MAX_SPEED, 16'(max_spd));
        write_reg(CFG_MIN_SPEED, 16'(min_spd));
        write_reg(CFG_HYSTERESIS, 16'(hyst));
        write_reg(CFG_EXPONENT, {14'($urandom), 2'(expo)});
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(2)), 16'($urandom));
        cfg_we <= 1'b0;
        cur_dz = dz;
    endtask

    // Mostly a stick moving smoothly, with excursions into the deadzone, onto its
    // edges and to full travel, and some unrelated samples.
    task automatic run_stick(input int n_items);
        int pos;
        int pick;
        pos = 0;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                pos = pos + int'($urandom_range(4000)) - 2000;
            end else if (pick < 77) begin
                pos = int'($urandom_range(cur_dz));
                if ($urandom_range(1)) begin
                    pos = -pos;
                end
            end else if (pick < 90) begin
                case ($urandom_range(5))
                    0: pos = 32767;
                    1: pos = -32768;
                    2: pos = cur_dz;
                    3: pos = -cur_dz;
                    4: pos = cur_dz + 1;
                    default: pos = -cur_dz - 1;
                endcase
            end else begin
                pos = int'($signed(16'($urandom)));
            end
            if (pos > 32767) begin
                pos = 32767;
            end
            if (pos < -32768) begin
                pos = -32768;
            end
            send_sample(pos);
        end
    endtask

    initial begin
        int dz;
        int min_spd;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        axis_value    = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DEADZONE;
        cfg_wdata     = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        cur_dz        = RST_DEADZONE;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: deadzone edges, starts, reversals, hysteresis and stops.
        send_sample(0);
        send_sample(8192);
        send_sample(-8192);
        send_sample(8193);
        send_sample(32767);
        send_sample(-32768);
        send_sample(-32767);
        send_sample(16384);
        send_sample(0);
        send_sample(0);
        send_sample(-8193);
        send_sample(20000);
        send_sample(20100);
        send_sample(26000);
        send_sample(0);
        settle();

        // Exponent zero must act as linear, then the cubic curve.
        write_config(8192, 16000, 250, 300, 0);
        send_sample(16384);
        send_sample(24576);
        settle();
        write_config(8192, 16000, 250, 300, 3);
        send_sample(-16384);
        send_sample(-24576);
        settle();

        // No deadzone and a zero speed range.
        write_config(0, 0, 0, 0, 1);
        send_sample(1);
        send_sample(-1);
        send_sample(0);
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct   = 51;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 51;
                end
                default: begin
                    in_idle_pct   = 31;
                    out_stall_pct = 31;
                end
            endcase
            case (p)
                0: write_config(0, 65535, 0, 0, 1);
                1: write_config(32767, 65535, 65535, 65535, 3);
                2: write_config(4000, 1000, 3000, 100, 0);
                3: write_config(32767, 0, 0, 0, 2);
                default: begin
                    dz = ($urandom_range(3) == 0) ? $urandom_range(32767)
                                                  : $urandom_range(20000);
                    min_spd = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(2000);
                    write_config(dz, $urandom_range(65535), min_spd,
                                 $urandom_range(1) ? $urandom_range(1500)
                                                   : $urandom_range(200),
                                 $urandom_range(3));
                end
            endcase
            // With the widest deadzone almost every sample is ignored, so those
            // phases are kept short.
            run_stick((cur_dz == 32767) ? 40 : PHASE_ITEMS + 40);
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
